>>> src/analog_ladder_switch_decoder_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef ANALOG_LADDER_SWITCH_DECODER_UNIT_MACROS_SVH
`define ANALOG_LADDER_SWITCH_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALSD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ALSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/alsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package alsd_pkg;

   localparam int TABLE_WIDTH = 12;
   localparam int LONG_COUNT  = 16;
   localparam int SHORT_COUNT = 9;
   localparam int INDEX_WIDTH = 4;
   localparam int TOL_WIDTH   = 8;

   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 8'd40;

   // Channel codes.
   localparam logic [1:0] CH_RIGHT = 2'd0;
   localparam logic [1:0] CH_JG    = 2'd1;
   localparam logic [1:0] CH_LEFT  = 2'd2;
   localparam logic [1:0] CH_OL    = 2'd3;

   typedef enum logic [1:0] {
      POS_UP     = 2'd0,
      POS_MIDDLE = 2'd1,
      POS_DOWN   = 2'd2,
      POS_NONE   = 2'd3
   } position_type;

   localparam logic [TABLE_WIDTH-1:0] LONG_LADDER [LONG_COUNT] = '{
      12'hDB0, 12'h5AA, 12'h9B2, 12'h1CA, 12'hE72, 12'h66A, 12'hA72, 12'h286,
      12'hBCA, 12'h3CE, 12'h7D4, 12'h000, 12'hC8A, 12'h48A, 12'h892, 12'h0B2
   };

   localparam logic [TABLE_WIDTH-1:0] SHORT_LADDER [SHORT_COUNT] = '{
      12'h9B2, 12'hA72, 12'h892, 12'hDB0, 12'hE72, 12'hC8A, 12'h5AA, 12'h66A,
      12'h48A
   };

   typedef struct packed {
      logic                   found;
      logic [INDEX_WIDTH-1:0] hit;
   } match_type;

   typedef struct packed {
      logic [3:0]   right_two;
      logic [3:0]   left_two;
      position_type sw_j;
      position_type sw_g;
      position_type sw_o;
      position_type sw_l;
   } held_type;

   typedef struct packed {
      position_type first;
      position_type second;
   } split_type;

   // A nine-entry index splits into two three-position switches.
   function automatic split_type split_three(input logic [INDEX_WIDTH-1:0] k);
      split_type s;
      unique case (k)
         4'd0:    s = '{POS_UP,     POS_UP};
         4'd1:    s = '{POS_UP,     POS_MIDDLE};
         4'd2:    s = '{POS_UP,     POS_DOWN};
         4'd3:    s = '{POS_MIDDLE, POS_UP};
         4'd4:    s = '{POS_MIDDLE, POS_MIDDLE};
         4'd5:    s = '{POS_MIDDLE, POS_DOWN};
         4'd6:    s = '{POS_DOWN,   POS_UP};
         4'd7:    s = '{POS_DOWN,   POS_MIDDLE};
         4'd8:    s = '{POS_DOWN,   POS_DOWN};
         default: s = '{POS_NONE,   POS_NONE};
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

>>> src/alsd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface alsd_req_if #(
   parameter int SAMPLE_WIDTH = 12
);
   logic                    valid;
   logic                    ready;
   logic [1:0]              channel;
   logic [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, channel, sample, input ready);
   modport sink   (input valid, channel, sample, output ready);
endinterface

interface alsd_rsp_if;
   logic       valid;
   logic       ready;
   logic       matched;
   logic [3:0] match_index;
   logic [3:0] right_two_pos;
   logic [3:0] left_two_pos;
   logic [1:0] switch_j;
   logic [1:0] switch_g;
   logic [1:0] switch_o;
   logic [1:0] switch_l;

   modport source (output valid, matched, match_index, right_two_pos, left_two_pos,
                   switch_j, switch_g, switch_o, switch_l, input ready);
   modport sink   (input valid, matched, match_index, right_two_pos, left_two_pos,
                   switch_j, switch_g, switch_o, switch_l, output ready);
endinterface

`default_nettype wire

>>> src/alsd_window_match.sv
`timescale 1ns / 1ps
`default_nettype none

module alsd_window_match #(
   parameter int SAMPLE_WIDTH = 12
) (
   input  wire logic [SAMPLE_WIDTH-1:0]          sample,
   input  wire logic [alsd_pkg::TOL_WIDTH-1:0]   tolerance,
   input  wire logic                             short_table,
   output alsd_pkg::match_type                   result
);

   // One spare bit so that the upper edge never wraps.
   localparam int CMP_WIDTH =
      ((SAMPLE_WIDTH > alsd_pkg::TABLE_WIDTH) ? SAMPLE_WIDTH : alsd_pkg::TABLE_WIDTH) + 1;

   logic [CMP_WIDTH-1:0]             sample_ext;
   logic [CMP_WIDTH-1:0]             tol_ext;
   logic [CMP_WIDTH-1:0]             upper;
   logic [CMP_WIDTH-1:0]             lower;
   logic [alsd_pkg::LONG_COUNT-1:0]  long_hits;
   logic [alsd_pkg::SHORT_COUNT-1:0] short_hits;
   logic [alsd_pkg::LONG_COUNT-1:0]  hits;

   always_comb begin
      sample_ext = CMP_WIDTH'(sample);
      tol_ext    = CMP_WIDTH'(tolerance);
      upper      = sample_ext + tol_ext;
      lower      = (sample_ext > tol_ext) ? (sample_ext - tol_ext) : '0;

      for (int k = 0; k < alsd_pkg::LONG_COUNT; k++) begin
         long_hits[k] = (CMP_WIDTH'(alsd_pkg::LONG_LADDER[k]) < upper) &&
                        (CMP_WIDTH'(alsd_pkg::LONG_LADDER[k]) > lower);
      end
      for (int k = 0; k < alsd_pkg::SHORT_COUNT; k++) begin
         short_hits[k] = (CMP_WIDTH'(alsd_pkg::SHORT_LADDER[k]) < upper) &&
                         (CMP_WIDTH'(alsd_pkg::SHORT_LADDER[k]) > lower);
      end

      hits = short_table ? alsd_pkg::LONG_COUNT'(short_hits) : long_hits;

      // The highest matching index wins; zero is left when nothing matches.
      result.found = |hits;
      result.hit   = '0;
      for (int k = 0; k < alsd_pkg::LONG_COUNT; k++) begin
         if (hits[k]) begin
            result.hit = alsd_pkg::INDEX_WIDTH'(k);
         end
      end
   end

endmodule

`default_nettype wire

>>> src/alsd_held_state.sv
`timescale 1ns / 1ps
`default_nettype none

module alsd_held_state (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                update,
   input  wire logic [1:0]          channel,
   input  wire alsd_pkg::match_type result,
   output alsd_pkg::held_type       held_next
);

   alsd_pkg::held_type  held_ff;
   alsd_pkg::held_type  held_in;
   alsd_pkg::split_type split;

   always_comb begin
      held_in = held_ff;
      split   = alsd_pkg::split_three(result.hit);
      if (update && result.found) begin
         unique case (channel)
            alsd_pkg::CH_RIGHT: held_in.right_two = result.hit;
            alsd_pkg::CH_LEFT:  held_in.left_two  = result.hit;
            alsd_pkg::CH_JG: begin
               held_in.sw_j = split.first;
               held_in.sw_g = split.second;
            end
            alsd_pkg::CH_OL: begin
               held_in.sw_o = split.first;
               held_in.sw_l = split.second;
            end
            default: held_in = held_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '{4'd0, 4'd0, alsd_pkg::POS_NONE, alsd_pkg::POS_NONE,
                      alsd_pkg::POS_NONE, alsd_pkg::POS_NONE};
      end else begin
         held_ff <= held_in;
      end
   end

   // The result reports the state as it stands after this request.
   assign held_next = held_in;

endmodule

`default_nettype wire

>>> src/analog_ladder_switch_decoder_unit.sv
// A request is held in the request register, then its response in the response register.
// Throughput: one request per cycle; the window compare sits between the
// request register and the response register and stalls only on rsp ready.
// Reset (synchronous, active high) empties both registers, sets the tolerance
// to 40, clears the two-position bits and marks every switch as not yet seen.
`timescale 1ns / 1ps
`default_nettype none

module analog_ladder_switch_decoder_unit #(
   parameter int SAMPLE_WIDTH = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [alsd_pkg::TOL_WIDTH-1:0] csr_wr_data,
   alsd_req_if.sink                            req_chan,
   alsd_rsp_if.source                          rsp_chan
);

   logic [alsd_pkg::TOL_WIDTH-1:0] tol_ff;
   logic [alsd_pkg::TOL_WIDTH-1:0] tol_in;

   logic                    stage_valid_ff;
   logic                    stage_valid_in;
   logic [1:0]              stage_channel_ff;
   logic [SAMPLE_WIDTH-1:0] stage_sample_ff;

   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic                             rsp_matched_ff;
   logic [alsd_pkg::INDEX_WIDTH-1:0] rsp_index_ff;
   alsd_pkg::held_type               rsp_held_ff;

   logic                advance;
   logic                req_take;
   alsd_pkg::match_type match;
   alsd_pkg::held_type  held_next;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !stage_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      tol_in         = csr_wr_en ? csr_wr_data : tol_ff;
      stage_valid_in = req_chan.ready ? req_chan.valid : stage_valid_ff;
      rsp_valid_in   = advance ? stage_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff         <= alsd_pkg::TOL_RESET;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         tol_ff         <= tol_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_channel_ff <= req_chan.channel;
         stage_sample_ff  <= req_chan.sample;
      end
      if (advance && stage_valid_ff) begin
         rsp_matched_ff <= match.found;
         rsp_index_ff   <= match.hit;
         rsp_held_ff    <= held_next;
      end
   end

   alsd_window_match #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_match (
      .sample      (stage_sample_ff),
      .tolerance   (tol_ff),
      .short_table (stage_channel_ff[0]),
      .result      (match)
   );

   alsd_held_state u_held (
      .clock     (clock),
      .reset     (reset),
      .update    (advance && stage_valid_ff),
      .channel   (stage_channel_ff),
      .result    (match),
      .held_next (held_next)
   );

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.matched       = rsp_matched_ff;
   assign rsp_chan.match_index   = rsp_index_ff;
   assign rsp_chan.right_two_pos = rsp_held_ff.right_two;
   assign rsp_chan.left_two_pos  = rsp_held_ff.left_two;
   assign rsp_chan.switch_j      = rsp_held_ff.sw_j;
   assign rsp_chan.switch_g      = rsp_held_ff.sw_g;
   assign rsp_chan.switch_o      = rsp_held_ff.sw_o;
   assign rsp_chan.switch_l      = rsp_held_ff.sw_l;

endmodule

`default_nettype wire

>>> src/alsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "analog_ladder_switch_decoder_unit_macros.svh"

module alsd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_matched,
   input wire logic [3:0] rsp_match_index,
   input wire logic [1:0] rsp_switch_j,
   input wire logic [1:0] rsp_switch_g,
   input wire logic [1:0] rsp_switch_o,
   input wire logic [1:0] rsp_switch_l
);

   logic        rsp_stall;
   logic [12:0] rsp_payload;
   logic        no_match;
   logic        j_none;
   logic        g_none;
   logic        o_none;
   logic        l_none;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_matched, rsp_match_index, rsp_switch_j, rsp_switch_g,
                         rsp_switch_o, rsp_switch_l};
   assign no_match    = rsp_valid && !rsp_matched;
   assign j_none      = (rsp_switch_j == alsd_pkg::POS_NONE);
   assign g_none      = (rsp_switch_g == alsd_pkg::POS_NONE);
   assign o_none      = (rsp_switch_o == alsd_pkg::POS_NONE);
   assign l_none      = (rsp_switch_l == alsd_pkg::POS_NONE);

   // A stalled response keeps its payload.
   `ALSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // Without a match the index reads as zero.
   `ALSD_ASSERT_SAME(a_no_match_index, clock, reset, no_match, rsp_match_index == 4'd0)

   // The two switches of one ladder are always set together.
   `ALSD_ASSERT_SAME(a_jg_pair, clock, reset, rsp_valid, j_none == g_none)
   `ALSD_ASSERT_SAME(a_ol_pair, clock, reset, rsp_valid, o_none == l_none)

endmodule

bind analog_ladder_switch_decoder_unit alsd_checker u_alsd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_matched     (rsp_chan.matched),
   .rsp_match_index (rsp_chan.match_index),
   .rsp_switch_j    (rsp_chan.switch_j),
   .rsp_switch_g    (rsp_chan.switch_g),
   .rsp_switch_o    (rsp_chan.switch_o),
   .rsp_switch_l    (rsp_chan.switch_l)
);

`default_nettype wire

>>> sim/analog_ladder_switch_decoder_unit_test.sv
`timescale 1ns / 1ps

module analog_ladder_switch_decoder_unit_test;
   import alsd_pkg::*;

   localparam int SAMPLE_BITS = 12;
   localparam int STALL_LIMIT = 1000;
   localparam int PHASE_REQUESTS = 200;

   typedef struct packed {
      logic                   matched;
      logic [INDEX_WIDTH-1:0] index;
      held_type               held;
   } ladder_result_type;

   // Tracks the held switch state and the queue of responses still owed.
   class ladder_ledger;
      logic [TOL_WIDTH-1:0] tolerance;
      logic [3:0]           two_pos [2];
      position_type         three_pos [4];
      ladder_result_type    awaited [$];
      int                   mismatches;

      function new();
         tolerance = TOL_RESET;
         two_pos = '{default: 4'd0};
         three_pos = '{default: POS_NONE};
         mismatches = 0;
      endfunction

      function void note_request(logic [1:0] channel, logic [SAMPLE_BITS-1:0] sample);
         int upper;
         int lower;
         int count;
         int entry;
         int hit;
         int base;
         bit long_table;
         bit found;
         ladder_result_type want;
         upper = int'(sample) + int'(tolerance);
         lower = (sample > tolerance) ? int'(sample) - int'(tolerance) : 0;
         long_table = (channel == CH_RIGHT) || (channel == CH_LEFT);
         count = long_table ? LONG_COUNT : SHORT_COUNT;
         found = 1'b0;
         hit = 0;
         // The window is open at both ends; a later entry overrides an earlier one.
         for (int k = 0; k < count; k++) begin
            entry = long_table ? int'(LONG_LADDER[k]) : int'(SHORT_LADDER[k]);
            if (entry < upper && entry > lower) begin
               found = 1'b1;
               hit = k;
            end
         end
         if (found) begin
            case (channel)
               CH_RIGHT: two_pos[0] = hit[3:0];
               CH_LEFT:  two_pos[1] = hit[3:0];
               default: begin
                  base = (channel == CH_JG) ? 0 : 2;
                  three_pos[base] = position_type'(2'(hit / 3));
                  three_pos[base + 1] = position_type'(2'(hit % 3));
               end
            endcase
         end
         want.matched = found;
         want.index = found ? hit[3:0] : 4'd0;
         want.held.right_two = two_pos[0];
         want.held.left_two = two_pos[1];
         want.held.sw_j = three_pos[0];
         want.held.sw_g = three_pos[1];
         want.held.sw_o = three_pos[2];
         want.held.sw_l = three_pos[3];
         awaited.push_back(want);
      endfunction

      function void report_fault(string what, logic [3:0] want, logic [3:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      endfunction

      function void compare_field(string what, logic [3:0] want, logic [3:0] got);
         if (got !== want)
            report_fault(what, want, got);
      endfunction

      function void check_response(ladder_result_type got);
         ladder_result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response arrived with no request outstanding", $time);
            return;
         end
         want = awaited.pop_front();
         compare_field("matched", want.matched, got.matched);
         compare_field("match_index", want.index, got.index);
         compare_field("right_two_pos", want.held.right_two, got.held.right_two);
         compare_field("left_two_pos", want.held.left_two, got.held.left_two);
         compare_field("switch_j", want.held.sw_j, got.held.sw_j);
         compare_field("switch_g", want.held.sw_g, got.held.sw_g);
         compare_field("switch_o", want.held.sw_o, got.held.sw_o);
         compare_field("switch_l", want.held.sw_l, got.held.sw_l);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [TOL_WIDTH-1:0] csr_wr_data;
   bit steady_flow;
   int quiet_cycles;
   ladder_ledger ledger;

   alsd_req_if #(.SAMPLE_WIDTH(SAMPLE_BITS)) req_bus ();
   alsd_rsp_if rsp_bus ();

   analog_ladder_switch_decoder_unit #(.SAMPLE_WIDTH(SAMPLE_BITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_chan   (req_bus),
      .rsp_chan   (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly short pauses, now and then a long one, none at all in a steady phase.
   function automatic int pick_gap();
      int roll;
      if (steady_flow)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [1:0] channel,
                                                         logic [TOL_WIDTH-1:0] tol);
      int centre;
      int spread;
      int value;
      if ($urandom_range(0, 99) < 30)
         return SAMPLE_BITS'($urandom);
      if (channel == CH_RIGHT || channel == CH_LEFT)
         centre = int'(LONG_LADDER[$urandom_range(0, LONG_COUNT - 1)]);
      else
         centre = int'(SHORT_LADDER[$urandom_range(0, SHORT_COUNT - 1)]);
      // Land close to a ladder voltage so that both window edges get exercised.
      spread = int'(tol) + 3;
      value = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (value < 0)
         value = 0;
      if (value > (1 << SAMPLE_BITS) - 1)
         value = (1 << SAMPLE_BITS) - 1;
      return value[SAMPLE_BITS-1:0];
   endfunction

   always @(posedge clock) begin
      ladder_result_type seen;
      bit rsp_taken;
      bit req_taken;
      if (!reset) begin
         rsp_taken = rsp_bus.valid && rsp_bus.ready;
         req_taken = req_bus.valid && req_bus.ready;
         if (rsp_taken) begin
            seen.matched = rsp_bus.matched;
            seen.index = rsp_bus.match_index;
            seen.held.right_two = rsp_bus.right_two_pos;
            seen.held.left_two = rsp_bus.left_two_pos;
            seen.held.sw_j = position_type'(rsp_bus.switch_j);
            seen.held.sw_g = position_type'(rsp_bus.switch_g);
            seen.held.sw_o = position_type'(rsp_bus.switch_o);
            seen.held.sw_l = position_type'(rsp_bus.switch_l);
            ledger.check_response(seen);
         end
         if (req_taken)
            ledger.note_request(req_bus.channel, req_bus.sample);
         if (rsp_taken || req_taken)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("** analog_ladder_switch_decoder_unit: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      int stall_left;
      int flow_left;
      rsp_bus.ready <= 1'b0;
      stall_left = 0;
      flow_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (flow_left > 0) begin
            flow_left--;
            rsp_bus.ready <= 1'b1;
         end else begin
            stall_left = pick_gap();
            flow_left = $urandom_range(1, 20);
            rsp_bus.ready <= (stall_left == 0);
         end
      end
   end

   task automatic send_request(input logic [1:0] channel, input logic [SAMPLE_BITS-1:0] sample);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.channel <= channel;
      req_bus.sample <= sample;
      do
         @(posedge clock);
      while (!req_bus.ready);
   endtask

   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      do
         @(posedge clock);
      while (ledger.awaited.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TOL_WIDTH-1:0] value);
      drain_responses();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ledger.tolerance = value;
   endtask

   initial begin
      logic [TOL_WIDTH-1:0] phase_tolerance [8];
      logic [1:0] channel;
      ledger = new();
      steady_flow = 1'b0;
      quiet_cycles = 0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.channel <= CH_RIGHT;
      req_bus.sample <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset tolerance: exact hits, the unreachable zero entry and both window edges.
      send_request(CH_RIGHT, 12'hDB0);
      send_request(CH_RIGHT, 12'h000);
      send_request(CH_RIGHT, 12'hFFF);
      send_request(CH_LEFT, 12'h0B2);
      send_request(CH_JG, 12'h9B2);
      send_request(CH_JG, 12'h48A);
      send_request(CH_OL, 12'hC8A);
      send_request(CH_OL, 12'hFFF);
      send_request(CH_LEFT, 12'h2AD);
      send_request(CH_LEFT, 12'h2AE);
      send_request(CH_RIGHT, 12'h583);
      send_request(CH_RIGHT, 12'h582);

      // Widest window: overlapping entries, where the highest index must win.
      write_tolerance(8'd255);
      send_request(CH_RIGHT, 12'h000);
      send_request(CH_LEFT, 12'hFFF);
      send_request(CH_JG, 12'hE72);
      send_request(CH_OL, 12'h900);
      send_request(CH_RIGHT, 12'hC00);

      // A zero tolerance leaves an empty window, so even exact values miss.
      write_tolerance(8'd0);
      send_request(CH_RIGHT, 12'hDB0);
      send_request(CH_JG, 12'h9B2);
      send_request(CH_LEFT, 12'h000);
      send_request(CH_OL, 12'hFFF);

      phase_tolerance = '{8'd40, 8'd1, 8'd255, 8'd128, TOL_WIDTH'($urandom), 8'd0,
                          TOL_WIDTH'($urandom), 8'd200};
      for (int phase = 0; phase < 8; phase++) begin
         write_tolerance(phase_tolerance[phase]);
         steady_flow = (phase == 3);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            channel = 2'($urandom);
            send_request(channel, pick_sample(channel, phase_tolerance[phase]));
         end
      end
      steady_flow = 1'b0;

      drain_responses();
      if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
         $display("** analog_ladder_switch_decoder_unit: PASSED **");
      else
         $display("** analog_ladder_switch_decoder_unit: FAILED **");
      $finish;
   end

endmodule
